// ===== sv/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Shutter command package
// Types, codes and reset values shared by the two-button shutter command block.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned HoldBits   = 16;
  localparam int unsigned LedBits    = 8;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 16;
  localparam int unsigned InBits     = 40;
  localparam int unsigned OutBits    = 24;

  localparam logic [HoldBits-1:0] HoldReset = HoldBits'(300);
  localparam logic [HoldBits-1:0] RunReset  = HoldBits'(300);
  localparam logic [LedBits-1:0]  LedReset  = LedBits'(100);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_HOLD_TIME = 2'd0,
    CFG_RUN_TIME  = 2'd1,
    CFG_LED_LEVEL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MOTOR_UNKNOWN = 2'd0,
    MOTOR_IDLE    = 2'd1,
    MOTOR_UP      = 2'd2,
    MOTOR_DOWN    = 2'd3
  } motor_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_GO   = 2'd1,
    ACT_STOP = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_HOLD  = 2'd2
  } btn_ev_e;

  typedef struct packed {
    btn_ev_e ev;
    logic    clear_req;
  } btn_out_t;

endpackage

// ===== sv/two_button_shutter_command.sv =====
// ----------------------------------------------------------------------------
// Two-button shutter command
// Turns button polls into up, down and stop commands with a run timer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         poll: time, button levels and click flags, motor state
//  m_axis    out        commands, clear requests, LED levels
//  cfg       in         register index and write data
//
// Each poll passes an input register and a result register; one item per cycle
// is sustained while m_axis_tready stays high.
// Reset clears all trackers and the run timer and loads the register defaults.
// A stalled result register holds the input register; the input side then
// stalls as well. Configuration writes are taken in every cycle.
module two_button_shutter_command (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // time_ms[31:0], up_level, up_click_flag, down_level, down_click_flag,
  // motor_state[1:0], zero pad
  input  logic [tsc_pkg::InBits-1:0]       s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // up_action[1:0], down_action[1:0], timer_stop, clear_up_events,
  // clear_down_events, led_up_out[7:0], led_down_out[7:0], zero pad
  output logic [tsc_pkg::OutBits-1:0]      m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsc_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [tsc_pkg::CfgBits-1:0]      cfg_data_i
);

  logic [tsc_pkg::HoldBits-1:0] hold_time_q, run_time_q;
  logic [tsc_pkg::LedBits-1:0]  led_level_q;

  logic                         in_valid_q, in_valid_d;
  logic [tsc_pkg::InBits-1:0]   in_data_q;
  logic                         out_valid_q, out_valid_d;
  logic [tsc_pkg::OutBits-1:0]  out_data_q, out_data_d;
  logic                         load, advance;

  logic [tsc_pkg::TimeBits-1:0] now;
  logic                         up_lv, up_ck, dn_lv, dn_ck;
  tsc_pkg::motor_e              motor;
  tsc_pkg::btn_out_t            up_out, dn_out;
  tsc_pkg::act_e                up_act, dn_act;
  logic                         up_run, dn_run, arm;
  logic                         armed_q, armed_d;
  logic [tsc_pkg::TimeBits-1:0] tstart_q, tstart_d;
  logic [tsc_pkg::TimeBits-1:0] run_elapsed;
  logic                         tstop;
  logic [tsc_pkg::LedBits-1:0]  led_up, led_dn;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= tsc_pkg::HoldReset;
      run_time_q  <= tsc_pkg::RunReset;
      led_level_q <= tsc_pkg::LedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tsc_pkg::CFG_HOLD_TIME: hold_time_q <= cfg_data_i;
        tsc_pkg::CFG_RUN_TIME:  run_time_q  <= cfg_data_i;
        tsc_pkg::CFG_LED_LEVEL: led_level_q <= cfg_data_i[tsc_pkg::LedBits-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = load ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d   = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign now   = in_data_q[31:0];
  assign up_lv = in_data_q[32];
  assign up_ck = in_data_q[33];
  assign dn_lv = in_data_q[34];
  assign dn_ck = in_data_q[35];
  assign motor = tsc_pkg::motor_e'(in_data_q[37:36]);

  tsc_button u_up (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .now_i       (now),
    .level_i     (up_lv),
    .click_i     (up_ck),
    .hold_time_i (hold_time_q),
    .out_o       (up_out)
  );

  tsc_button u_down (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .now_i       (now),
    .level_i     (dn_lv),
    .click_i     (dn_ck),
    .hold_time_i (hold_time_q),
    .out_o       (dn_out)
  );

  assign up_run = motor == tsc_pkg::MOTOR_UP;
  assign dn_run = motor == tsc_pkg::MOTOR_DOWN;

  always_comb begin
    up_act = tsc_pkg::ACT_NONE;
    if (up_out.ev != tsc_pkg::EV_NONE) begin
      up_act = up_run ? tsc_pkg::ACT_STOP : tsc_pkg::ACT_GO;
    end
    dn_act = tsc_pkg::ACT_NONE;
    if (dn_out.ev != tsc_pkg::EV_NONE) begin
      dn_act = dn_run ? tsc_pkg::ACT_STOP : tsc_pkg::ACT_GO;
    end
  end

  assign arm = (up_out.ev == tsc_pkg::EV_CLICK && !up_run) ||
               (dn_out.ev == tsc_pkg::EV_CLICK && !dn_run);
  assign run_elapsed = now - tstart_q;

  always_comb begin
    tstart_d = arm ? now : tstart_q;
    if (arm) begin
      tstop = run_time_q == '0;
    end else begin
      tstop = armed_q && (run_elapsed >= tsc_pkg::TimeBits'(run_time_q));
    end
    armed_d = (armed_q || arm) && !tstop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b0;
      tstart_q <= '0;
    end else if (advance) begin
      armed_q  <= armed_d;
      tstart_q <= tstart_d;
    end
  end

  assign led_up = up_run ? led_level_q : '0;
  assign led_dn = dn_run ? led_level_q : '0;

  assign out_data_d = {1'b0, led_dn, led_up, dn_out.clear_req, up_out.clear_req,
                       tstop, dn_act, up_act};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while both stages are stalled");

  a_timer_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && tstop |=> !armed_q)
    else $error("run timer still armed after it expired");

  a_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[14:7] == '0 || out_data_q[22:15] == '0))
    else $error("both direction LEDs lit");

  a_stop_needs_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && tstop && !arm |-> armed_q)
    else $error("timer stop without an armed timer");

endmodule

// ===== sv/tsc_button.sv =====
// ----------------------------------------------------------------------------
// Button press tracker
// Tracks one button's press start, hold and pressed flags and reports events.
// ----------------------------------------------------------------------------
module tsc_button (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [tsc_pkg::TimeBits-1:0]  now_i,
  input  logic                          level_i,
  input  logic                          click_i,
  input  logic [tsc_pkg::HoldBits-1:0]  hold_time_i,
  output tsc_pkg::btn_out_t             out_o
);

  logic                         seen_q, seen_d;
  logic                         hold_q, hold_d;
  logic [tsc_pkg::TimeBits-1:0] start_q, start_d;
  logic [tsc_pkg::TimeBits-1:0] elapsed;
  logic                         hold_due;

  assign elapsed  = now_i - start_q;
  assign hold_due = elapsed >= tsc_pkg::TimeBits'(hold_time_i);

  always_comb begin
    seen_d        = seen_q;
    hold_d        = hold_q;
    start_d       = start_q;
    out_o.ev        = tsc_pkg::EV_NONE;
    out_o.clear_req = 1'b0;
    if (!seen_q && level_i) begin
      seen_d          = 1'b1;
      hold_d          = 1'b0;
      start_d         = now_i;
      out_o.clear_req = 1'b1;
    end else if (seen_q && level_i) begin
      if (!hold_q && hold_due) begin
        hold_d   = 1'b1;
        out_o.ev = tsc_pkg::EV_HOLD;
      end
    end else if (seen_q && click_i) begin
      seen_d          = 1'b0;
      out_o.clear_req = 1'b1;
      if (!hold_q) begin
        out_o.ev = tsc_pkg::EV_CLICK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      hold_q  <= 1'b0;
      start_q <= '0;
    end else if (en_i) begin
      seen_q  <= seen_d;
      hold_q  <= hold_d;
      start_q <= start_d;
    end
  end

endmodule
